/* hdl/bswd_pkg.sv */
// ----------------------------------------------------------------------------
// bswd_pkg
// Shared types and constants of the bright spot window detector.
// ----------------------------------------------------------------------------
package bswd_pkg;

    localparam int PIX_W   = 8;     // grey pixel
    localparam int SPOT_XW = 10;    // reported column
    localparam int ROW_W   = 12;    // row counter and reported row
    localparam int COL_W   = 11;    // one vertical column sum of 7 pixels
    localparam int WIN_W   = 14;    // 7x7 window sum plus center
    localparam int LINES   = 6;     // line buffers held per column
    localparam int WIN     = 7;     // window size
    localparam int CEN_TAP = 2;     // line buffer that holds the center row
    localparam int CEN_DLY = 4;     // center pixel delay, in columns
    localparam int OFFSET  = 3;     // window half size
    localparam int MIN_DIM = 7;     // smallest frame side
    localparam int MAX_ROWS = 4095;
    localparam int MEAN_GAIN = 49;  // pixels in the window

    localparam logic [10:0] RST_FRAME_WIDTH  = 11'd640;
    localparam logic [11:0] RST_FRAME_HEIGHT = 12'd480;
    localparam logic [7:0]  RST_BRIGHT_LEVEL = 8'd220;
    localparam logic [7:0]  RST_MEAN_LIMIT   = 8'd50;

    typedef enum logic [1:0] {
        CFG_FRAME_WIDTH,
        CFG_FRAME_HEIGHT,
        CFG_BRIGHT_LEVEL,
        CFG_MEAN_LIMIT
    } t_cfg_idx;

    // per-pixel control that rides along the pipeline
    typedef struct packed {
        logic                test_en;   // window lies fully inside the frame
        logic                last;      // last pixel of the frame
        logic                clr;       // frame start, restart the search
        logic [SPOT_XW-1:0]  spot_x;    // center column of this window
        logic [ROW_W-1:0]    spot_y;    // center row of this window
    } t_stage_ctl;

    typedef struct packed {
        logic                found;
        logic [SPOT_XW-1:0]  spot_x;
        logic [ROW_W-1:0]    spot_y;
    } t_result;

endpackage

/* hdl/bright_spot_window_detector.sv */
// ----------------------------------------------------------------------------
// Result path: after the last pixel transfer of a frame, the result passes the
//   memory read, column sum, window test and result queue, then is held until taken.
// Throughput: one pixel per cycle while the result queue leaves o_in_ready high.
// Reset: counters, search state and config go to defaults; the line memory
//   is not cleared and holds undefined data until written.
// ----------------------------------------------------------------------------
// bright_spot_window_detector
// Finds the first pixel in raster order whose 7x7 window score (window sum
// plus the center) exceeds 49 x mean_limit and whose value is at least
// bright_level. One result per frame: found flag and spot coordinates.
// ----------------------------------------------------------------------------
module bright_spot_window_detector #(
    parameter int MAX_WIDTH = 1024
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    // pixel input
    input  logic                          i_in_valid,
    output logic                          o_in_ready,
    input  logic [bswd_pkg::PIX_W-1:0]    i_pixel,
    input  logic                          i_frame_start,
    // result output
    output logic                          o_out_valid,
    input  logic                          i_out_ready,
    output logic                          o_found,
    output logic [bswd_pkg::SPOT_XW-1:0]  o_spot_x,
    output logic [bswd_pkg::ROW_W-1:0]    o_spot_y,
    // register writes
    input  logic                          i_cfg_valid,
    output logic                          o_cfg_ready,
    input  logic [1:0]                    i_cfg_index,
    input  logic [11:0]                   i_cfg_data
);
    import bswd_pkg::*;

    localparam int XW = $clog2(MAX_WIDTH);
    localparam logic [12:0] MAXW13 = 13'(MAX_WIDTH);
    localparam logic [12:0] MIN13  = 13'(MIN_DIM);
    localparam logic [11:0] MINH   = 12'(MIN_DIM);
    localparam logic [12:0] EDGE13 = 13'(WIN - 1);
    localparam logic [11:0] EDGEH  = 12'(WIN - 1);

    // config registers
    logic [10:0]      r_frame_width;
    logic [11:0]      r_frame_height;
    logic [7:0]       r_bright_level;
    logic [7:0]       r_mean_limit;

    // raster position of the next pixel
    logic [XW-1:0]    r_col;
    logic [ROW_W-1:0] r_row;

    logic             accept;
    logic [12:0]      cfg_w13;
    logic [12:0]      w13;
    logic [12:0]      wlast13;
    logic [11:0]      h12;
    logic [11:0]      hlast;
    logic [XW-1:0]    x;
    logic [12:0]      x13;
    logic [XW+9:0]    x_ext;
    logic [ROW_W-1:0] y;
    logic             row_end;
    logic             frame_end;
    t_stage_ctl       ctl0;

    logic             ls_valid;
    logic [COL_W-1:0] ls_col;
    logic [PIX_W-1:0] ls_cen;
    t_stage_ctl       ls_ctl;
    logic             ls_pending;
    logic             win_push;
    t_result          win_result;
    logic             win_pending;
    t_result          out_data;
    logic [1:0]       out_count;
    logic             pending;

    // config port is always open; the source must write only while idle, the block does not enforce it
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_frame_width  <= RST_FRAME_WIDTH;
            r_frame_height <= RST_FRAME_HEIGHT;
            r_bright_level <= RST_BRIGHT_LEVEL;
            r_mean_limit   <= RST_MEAN_LIMIT;
        end else if (i_cfg_valid) begin
            unique case (t_cfg_idx'(i_cfg_index))
                CFG_FRAME_WIDTH:  r_frame_width  <= i_cfg_data[10:0];
                CFG_FRAME_HEIGHT: r_frame_height <= i_cfg_data;
                CFG_BRIGHT_LEVEL: r_bright_level <= i_cfg_data[7:0];
                CFG_MEAN_LIMIT:   r_mean_limit   <= i_cfg_data[7:0];
            endcase
        end
    end

    // effective geometry: width clamped to [7, MAX_WIDTH], height to [7, 4095]
    always_comb begin
        cfg_w13 = 13'(r_frame_width);
        if (cfg_w13 < MIN13) begin
            w13 = MIN13;
        end else if (cfg_w13 > MAXW13) begin
            w13 = MAXW13;
        end else begin
            w13 = cfg_w13;
        end
        wlast13 = w13 - 13'd1;
        // upper clamp is the all-ones code, nothing to do there
        h12   = (r_frame_height < MINH) ? MINH : r_frame_height;
        hlast = h12 - 12'd1;
    end

    // Input gating: at most one result can be in flight (a frame is at
    // least 7x7 pixels), so keep one queue slot free for it.
    assign pending    = ls_pending || win_pending;
    assign o_in_ready = (out_count == 2'd0) || ((out_count == 2'd1) && !pending);
    assign accept     = i_in_valid && o_in_ready;

    // position of this pixel; frame start restarts at the origin
    always_comb begin
        x         = i_frame_start ? '0 : r_col;
        y         = i_frame_start ? '0 : r_row;
        x13       = 13'(x);
        x_ext     = {10'd0, x};
        row_end   = (x13 >= wlast13);
        frame_end = row_end && (y >= hlast);

        // window fully inside: 6 <= x < w and 6 <= y < h at the bottom-right
        // pixel, center is three back on both axes
        ctl0.test_en = (x13 >= EDGE13) && (y >= EDGEH) && (x13 < w13) && (y < h12);
        ctl0.last    = frame_end;
        ctl0.clr     = i_frame_start;
        ctl0.spot_x  = x_ext[SPOT_XW-1:0] - SPOT_XW'(OFFSET);
        ctl0.spot_y  = y - ROW_W'(OFFSET);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col <= '0;
            r_row <= '0;
        end else if (accept) begin
            if (row_end) begin
                r_col <= '0;
                r_row <= frame_end ? '0 : (y + ROW_W'(1));
            end else begin
                r_col <= x + XW'(1);
                r_row <= y;
            end
        end
    end

    // stage 1-2: line memory read-modify-write and vertical column sum
    bswd_line_store #(
        .MAX_WIDTH (MAX_WIDTH)
    ) u_line_store (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_valid   (accept),
        .i_addr    (x),
        .i_pixel   (i_pixel),
        .i_ctl     (ctl0),
        .o_valid   (ls_valid),
        .o_col_sum (ls_col),
        .o_center  (ls_cen),
        .o_ctl     (ls_ctl),
        .o_pending (ls_pending)
    );

    // stage 3: horizontal window, threshold test, first-hit capture
    bswd_window u_window (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (ls_valid),
        .i_col_sum      (ls_col),
        .i_center       (ls_cen),
        .i_ctl          (ls_ctl),
        .i_bright_level (r_bright_level),
        .i_mean_limit   (r_mean_limit),
        .o_push         (win_push),
        .o_result       (win_result),
        .o_pending      (win_pending)
    );

    // result queue decouples the pixel side from a stalled consumer
    bswd_out_fifo u_out_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (win_push),
        .i_data  (win_result),
        .o_valid (o_out_valid),
        .i_ready (i_out_ready),
        .o_data  (out_data),
        .o_count (out_count)
    );

    assign o_found  = out_data.found;
    assign o_spot_x = out_data.spot_x;
    assign o_spot_y = out_data.spot_y;

endmodule

/* hdl/bswd_line_store.sv */
// ----------------------------------------------------------------------------
// bswd_line_store
// Six-line pixel memory, one 48-bit word per column. Read on transfer,
// column sum and write-back in the next cycle, with same-column forwarding.
// ----------------------------------------------------------------------------
module bswd_line_store #(
    parameter int MAX_WIDTH = 1024
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_valid,
    input  logic [$clog2(MAX_WIDTH)-1:0]  i_addr,
    input  logic [bswd_pkg::PIX_W-1:0]    i_pixel,
    input  bswd_pkg::t_stage_ctl          i_ctl,
    output logic                          o_valid,
    output logic [bswd_pkg::COL_W-1:0]    o_col_sum,
    output logic [bswd_pkg::PIX_W-1:0]    o_center,
    output bswd_pkg::t_stage_ctl          o_ctl,
    output logic                          o_pending
);
    import bswd_pkg::*;

    localparam int XW = $clog2(MAX_WIDTH);
    localparam int DW = LINES * PIX_W;

    logic [DW-1:0]    r_mem [MAX_WIDTH];
    logic [DW-1:0]    r_rdata;
    logic             r_v1;
    logic [XW-1:0]    r_x1;
    logic [PIX_W-1:0] r_pix1;
    t_stage_ctl       r_ctl1;
    logic             r_fwd_v;
    logic [DW-1:0]    r_fwd_d;

    logic             r_v2;
    logic [COL_W-1:0] r_col2;
    logic [PIX_W-1:0] r_cen2;
    t_stage_ctl       r_ctl2;

    logic [DW-1:0]    word;
    logic [DW-1:0]    wdata;
    logic [COL_W-1:0] col;

    always_comb begin
        word  = r_fwd_v ? r_fwd_d : r_rdata;
        wdata = {word[DW-PIX_W-1:0], r_pix1};
        col   = COL_W'(r_pix1);
        for (int i = 0; i < LINES; i++) begin
            col = col + COL_W'(word[i*PIX_W +: PIX_W]);
        end
    end

    // memory port: read at transfer, write back the shifted column
    always_ff @(posedge i_clk) begin
        if (i_valid) begin
            r_rdata <= r_mem[i_addr];
        end
        if (r_v1) begin
            r_mem[r_x1] <= wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1    <= 1'b0;
            r_v2    <= 1'b0;
            r_fwd_v <= 1'b0;
        end else begin
            r_v1    <= i_valid;
            r_v2    <= r_v1;
            // a read that collides with this cycle's write takes the written word from the forward register
            r_fwd_v <= i_valid && r_v1 && (i_addr == r_x1);
        end
    end

    always_ff @(posedge i_clk) begin
        r_fwd_d <= wdata;
        if (i_valid) begin
            r_x1   <= i_addr;
            r_pix1 <= i_pixel;
            r_ctl1 <= i_ctl;
        end
        if (r_v1) begin
            r_col2 <= col;
            r_cen2 <= word[CEN_TAP*PIX_W +: PIX_W];
            r_ctl2 <= r_ctl1;
        end
    end

    assign o_valid   = r_v2;
    assign o_col_sum = r_col2;
    assign o_center  = r_cen2;
    assign o_ctl     = r_ctl2;
    assign o_pending = (r_v1 && r_ctl1.last) || (r_v2 && r_ctl2.last);

endmodule

/* hdl/bswd_window.sv */
// ----------------------------------------------------------------------------
// bswd_window
// Seven column sums added into the window total, center delay line,
// threshold test and first-hit tracking.
// ----------------------------------------------------------------------------
module bswd_window (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_valid,
    input  logic [bswd_pkg::COL_W-1:0]  i_col_sum,
    input  logic [bswd_pkg::PIX_W-1:0]  i_center,
    input  bswd_pkg::t_stage_ctl        i_ctl,
    input  logic [7:0]                  i_bright_level,
    input  logic [7:0]                  i_mean_limit,
    output logic                        o_push,
    output bswd_pkg::t_result           o_result,
    output logic                        o_pending
);
    import bswd_pkg::*;

    // the six older columns; the newest one arrives on i_col_sum
    logic [COL_W-1:0]   r_cs [WIN-1];
    // centers of the three previous columns; r_cen3 is the fourth tap
    logic [PIX_W-1:0]   r_cp [CEN_DLY-1];
    logic [WIN_W-1:0]   r_win;

    logic               r_v3;
    logic [PIX_W-1:0]   r_cen3;
    t_stage_ctl         r_ctl3;

    logic               r_hit;
    logic [SPOT_XW-1:0] r_hx;
    logic [ROW_W-1:0]   r_hy;

    logic [WIN_W-1:0]   n_win;
    logic [WIN_W-1:0]   score;
    logic [WIN_W-1:0]   limit;
    logic               hit_cur;
    logic               qual;
    logic               n_hit;
    logic [SPOT_XW-1:0] n_hx;
    logic [ROW_W-1:0]   n_hy;

    // window total of the seven newest columns, rebuilt every transfer
    always_comb begin
        n_win = WIN_W'(i_col_sum);
        for (int i = 0; i < WIN - 1; i++) begin
            n_win = n_win + WIN_W'(r_cs[i]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < WIN - 1; i++) begin
                r_cs[i] <= '0;
            end
            for (int i = 0; i < CEN_DLY - 1; i++) begin
                r_cp[i] <= '0;
            end
            r_win <= '0;
            r_v3  <= 1'b0;
        end else begin
            r_v3 <= i_valid;
            if (i_valid) begin
                r_cs[0] <= i_col_sum;
                for (int i = 1; i < WIN - 1; i++) begin
                    r_cs[i] <= r_cs[i-1];
                end
                r_cp[0] <= i_center;
                for (int i = 1; i < CEN_DLY - 1; i++) begin
                    r_cp[i] <= r_cp[i-1];
                end
                r_win <= n_win;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_valid) begin
            r_cen3 <= r_cp[CEN_DLY-2];
            r_ctl3 <= i_ctl;
        end
    end

    // test stage
    always_comb begin
        score   = r_win + WIN_W'(r_cen3);
        limit   = WIN_W'(i_mean_limit) * WIN_W'(MEAN_GAIN);
        hit_cur = r_hit && !r_ctl3.clr;
        qual    = r_ctl3.test_en && !hit_cur && (r_cen3 >= i_bright_level)
                  && (score > limit);
        n_hit   = hit_cur || qual;
        n_hx    = qual ? r_ctl3.spot_x : (hit_cur ? r_hx : '0);
        n_hy    = qual ? r_ctl3.spot_y : (hit_cur ? r_hy : '0);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hit <= 1'b0;
            r_hx  <= '0;
            r_hy  <= '0;
        end else if (r_v3) begin
            if (r_ctl3.last) begin
                r_hit <= 1'b0;
                r_hx  <= '0;
                r_hy  <= '0;
            end else begin
                r_hit <= n_hit;
                r_hx  <= n_hx;
                r_hy  <= n_hy;
            end
        end
    end

    assign o_push          = r_v3 && r_ctl3.last;
    assign o_result.found  = n_hit;
    assign o_result.spot_x = n_hx;
    assign o_result.spot_y = n_hy;
    assign o_pending       = r_v3 && r_ctl3.last;

endmodule

/* hdl/bswd_out_fifo.sv */
// ----------------------------------------------------------------------------
// bswd_out_fifo
// Two-entry result queue between the detector and the result channel.
// ----------------------------------------------------------------------------
module bswd_out_fifo (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_push,
    input  bswd_pkg::t_result   i_data,
    output logic                o_valid,
    input  logic                i_ready,
    output bswd_pkg::t_result   o_data,
    output logic [1:0]          o_count
);
    import bswd_pkg::*;

    t_result    r_mem [2];
    logic       r_wp;
    logic       r_rp;
    logic [1:0] r_cnt;
    logic       pop;

    assign pop = (r_cnt != 2'd0) && i_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (i_push) begin
                r_wp <= ~r_wp;
            end
            if (pop) begin
                r_rp <= ~r_rp;
            end
            r_cnt <= r_cnt + 2'(i_push) - 2'(pop);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wp] <= i_data;
        end
    end

    assign o_valid = (r_cnt != 2'd0);
    assign o_data  = r_mem[r_rp];
    assign o_count = r_cnt;

endmodule
